FILE: hw/rtl/oart_pkg.sv
// Shared types and constants for the object access rights table.
`timescale 1ns / 1ps

package oart_pkg;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_ADD_ATTR = 4'd1,
    OP_ADD_METH = 4'd2,
    OP_REMOVE   = 4'd3,
    OP_FIND     = 4'd4,
    OP_READ     = 4'd5,
    OP_WRITE    = 4'd6,
    OP_INVOKE   = 4'd7,
    OP_CLEAR    = 4'd8
  } opcode_e;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOROOM   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  // attribute access modes
  localparam logic [2:0] AM_R       = 3'd1;
  localparam logic [2:0] AM_W       = 3'd2;
  localparam logic [2:0] AM_RW      = 3'd3;
  localparam logic [2:0] AM_AUTH_R  = 3'd4;
  localparam logic [2:0] AM_AUTH_W  = 3'd5;
  localparam logic [2:0] AM_AUTH_RW = 3'd6;

  // method access modes
  localparam logic [1:0] MM_YES     = 2'd1;
  localparam logic [1:0] MM_AUTH    = 2'd2;
  localparam logic [1:0] MM_NOGRANT = 2'd3;
  localparam logic [2:0] MM_MAX_IN  = 3'd2;

  typedef enum logic [1:0] {
    PA_PTR,
    PA_NEXT,
    PA_COUNT,
    PA_LAST
  } pos_sel_e;

  typedef enum logic [2:0] {
    RK_OK_ZERO,
    RK_OK_IDX,
    RK_NOROOM_ZERO,
    RK_NOROOM_IDX,
    RK_NOTFOUND,
    RK_CHECK,
    RK_CHECK_MISS
  } res_kind_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_ADD_WR,
    S_OK_IDX,
    S_AR_CAP,
    S_AR_DO,
    S_SCAN_ADDR,
    S_SCAN_CMP,
    S_FOUND,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RIGHT_ADDR,
    S_RIGHT_CMP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic      load_in;
    pos_sel_e  pos_sel;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      k_clr;
    logic      k_inc;
    logic      capture;
    logic      add_commit;
    logic      right_commit;
    logic      shift_write;
    logic      remove_commit;
    logic      clear_commit;
    logic      res_set;
    res_kind_e res_kind;
    logic      out_load;
  } oart_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    full;
    logic    empty;
    logic    scan_end;
    logic    key_hit;
    logic    shift_end;
    logic    right_end;
    logic    right_hit;
    logic    right_full;
    logic    out_free;
  } oart_stat_t;

endpackage

FILE: hw/rtl/object_access_rights_table.sv
// Top level of the object access rights table.
`timescale 1ns / 1ps

// channel  | valid       | stall        | word
// ---------+-------------+--------------+-----------------------------------------------
// in       | in_valid_i  | in_stall_o   | opcode, obj_class, obj_name, item_id, right_mode
// out      | out_valid_o | out_stall_i  | status, allowed, entry_index
// cfg      | cfg_we_i    | (none)       | cfg_wdata_i -> auth_mechanism
//
// One word at a time. Lookups take an address and a compare step per key; removal adds
// a read and a write step per later key; checks, an address and a compare step per right.
// Rights live in per-slot memories reached through a slot map, so removal never moves them.
// Reset clears entry count, slot high mark, auth register and output valid; no clearing pass.
// Input is taken only when the sequencer is idle; a finished word waits in the output
// register while the next input is accepted.
module object_access_rights_table #(
  parameter int MAX_ENTRIES  = 64,
  parameter int ATTR_SLOTS   = 16,
  parameter int METHOD_SLOTS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [3:0]        opcode_i,
  input  logic [15:0]       obj_class_i,
  input  logic [47:0]       obj_name_i,
  input  logic signed [7:0] item_id_i,
  input  logic [2:0]        right_mode_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic              allowed_o,
  output logic [5:0]        entry_index_o
);
  import oart_pkg::*;

  oart_cmd_t  cmd;
  oart_stat_t stat;

  // sequencer: one state per memory access or compare step
  oart_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stores, scan pointers and result register
  oart_dp #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .ATTR_SLOTS   (ATTR_SLOTS),
    .METHOD_SLOTS (METHOD_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .opcode_i       (opcode_i),
    .obj_class_i    (obj_class_i),
    .obj_name_i     (obj_name_i),
    .item_id_i      (item_id_i),
    .right_mode_i   (right_mode_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .allowed_o      (allowed_o),
    .entry_index_o  (entry_index_o)
  );

endmodule

FILE: hw/rtl/oart_ctrl.sv
// Sequencing controller for the object access rights table.
`timescale 1ns / 1ps

module oart_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  oart_pkg::oart_stat_t stat_i,
  output oart_pkg::oart_cmd_t  cmd_o
);
  import oart_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.pos_sel  = PA_PTR;
    cmd_o.res_kind = RK_OK_ZERO;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.op) inside
          OP_ADD: begin
            if (stat_i.full) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = RK_NOROOM_ZERO;
              state_d = S_RESP;
            end else begin
              cmd_o.pos_sel = PA_COUNT;
              state_d = S_ADD_WR;
            end
          end
          OP_ADD_ATTR, OP_ADD_METH: begin
            if (stat_i.empty) begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_kind = RK_NOTFOUND;
              state_d = S_RESP;
            end else begin
              cmd_o.pos_sel = PA_LAST;
              state_d = S_AR_CAP;
            end
          end
          OP_REMOVE, OP_FIND, OP_READ, OP_WRITE, OP_INVOKE: begin
            cmd_o.ptr_clr = 1'b1;
            state_d = S_SCAN_ADDR;
          end
          OP_CLEAR: begin
            cmd_o.clear_commit = 1'b1;
            cmd_o.res_set  = 1'b1;
            cmd_o.res_kind = RK_OK_ZERO;
            state_d = S_RESP;
          end
          default: begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_kind = RK_OK_ZERO;
            state_d = S_RESP;
          end
        endcase
      end
      S_ADD_WR: begin
        cmd_o.add_commit = 1'b1;
        state_d = S_OK_IDX;
      end
      S_OK_IDX: begin
        cmd_o.res_set  = 1'b1;
        cmd_o.res_kind = RK_OK_IDX;
        state_d = S_RESP;
      end
      S_AR_CAP: begin
        cmd_o.capture = 1'b1;
        state_d = S_AR_DO;
      end
      S_AR_DO: begin
        if (stat_i.right_full) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RK_NOROOM_IDX;
          state_d = S_RESP;
        end else begin
          cmd_o.right_commit = 1'b1;
          state_d = S_OK_IDX;
        end
      end
      S_SCAN_ADDR: begin
        if (stat_i.scan_end) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RK_NOTFOUND;
          state_d = S_RESP;
        end else begin
          cmd_o.pos_sel = PA_PTR;
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat_i.key_hit) begin
          cmd_o.capture = 1'b1;
          state_d = S_FOUND;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d = S_SCAN_ADDR;
        end
      end
      S_FOUND: begin
        case (stat_i.op)
          OP_REMOVE: state_d = S_SHIFT_RD;
          OP_FIND: begin
            cmd_o.res_set  = 1'b1;
            cmd_o.res_kind = RK_OK_IDX;
            state_d = S_RESP;
          end
          default: begin
            cmd_o.k_clr = 1'b1;
            state_d = S_RIGHT_ADDR;
          end
        endcase
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_end) begin
          cmd_o.remove_commit = 1'b1;
          state_d = S_OK_IDX;
        end else begin
          cmd_o.pos_sel = PA_NEXT;
          state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_write = 1'b1;
        cmd_o.ptr_inc     = 1'b1;
        state_d = S_SHIFT_RD;
      end
      S_RIGHT_ADDR: begin
        if (stat_i.right_end) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RK_CHECK_MISS;
          state_d = S_RESP;
        end else begin
          state_d = S_RIGHT_CMP;
        end
      end
      S_RIGHT_CMP: begin
        if (stat_i.right_hit) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_kind = RK_CHECK;
          state_d = S_RESP;
        end else begin
          cmd_o.k_inc = 1'b1;
          state_d = S_RIGHT_ADDR;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/oart_dp.sv
// Datapath of the object access rights table: stores, pointers, result register.
`timescale 1ns / 1ps

module oart_dp #(
  parameter int MAX_ENTRIES  = 64,
  parameter int ATTR_SLOTS   = 16,
  parameter int METHOD_SLOTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_wdata_i,
  input  logic [3:0]           opcode_i,
  input  logic [15:0]          obj_class_i,
  input  logic [47:0]          obj_name_i,
  input  logic signed [7:0]    item_id_i,
  input  logic [2:0]           right_mode_i,
  input  logic                 out_stall_i,
  input  oart_pkg::oart_cmd_t  cmd_i,
  output oart_pkg::oart_stat_t stat_o,
  output logic                 out_valid_o,
  output logic [1:0]           status_o,
  output logic                 allowed_o,
  output logic [5:0]           entry_index_o
);
  import oart_pkg::*;

  localparam int PW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW   = $clog2(MAX_ENTRIES + 1);
  localparam int ACW  = $clog2(ATTR_SLOTS + 1);
  localparam int MCW  = $clog2(METHOD_SLOTS + 1);
  localparam int KW   = (ACW > MCW) ? ACW : MCW;
  localparam int ADEP = MAX_ENTRIES * ATTR_SLOTS;
  localparam int MDEP = MAX_ENTRIES * METHOD_SLOTS;
  localparam int AAW  = (ADEP > 1) ? $clog2(ADEP) : 1;
  localparam int MAW  = (MDEP > 1) ? $clog2(MDEP) : 1;

  // stores: per position (keys, counts, slot map) and per physical slot (rights)
  logic [63:0]  key_mem  [MAX_ENTRIES];
  logic [ACW-1:0] acnt_mem [MAX_ENTRIES];
  logic [MCW-1:0] mcnt_mem [MAX_ENTRIES];
  logic [PW-1:0]  map_mem  [MAX_ENTRIES];
  logic [10:0]  attr_mem [ADEP];
  logic [9:0]   meth_mem [MDEP];

  logic [63:0]    key_rd_q;
  logic [ACW-1:0] acnt_rd_q;
  logic [MCW-1:0] mcnt_rd_q;
  logic [PW-1:0]  map_rd_q;
  logic [PW-1:0]  rd_addr_q;
  logic [10:0]    attr_rd_q;
  logic [9:0]     meth_rd_q;

  opcode_e     op_q;
  logic [63:0] key_q;
  logic [7:0]  id_q;
  logic [2:0]  mode_q;
  logic [CW-1:0] count_q, hi_q, ptr_q, ptr_nxt, count_last;
  logic [KW-1:0] k_q, cnt_q, rk;
  logic [PW-1:0] idx_q, slot_q, pos_addr, pos_waddr, new_slot;
  logic [2:0]  auth_q;
  logic [1:0]  res_status_q;
  logic        res_allowed_q;
  logic [5:0]  res_idx_q;
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic        out_allowed_q;
  logic [5:0]  out_idx_q;

  logic [AAW-1:0] attr_addr;
  logic [MAW-1:0] meth_addr;
  logic        key_we, acnt_we, mcnt_we, map_we, attr_we, meth_we;
  logic [63:0] key_wd;
  logic [ACW-1:0] acnt_wd;
  logic [MCW-1:0] mcnt_wd;
  logic [PW-1:0]  map_wd;
  logic [1:0]  meth_mode;
  logic        authed, grant;

  assign ptr_nxt    = ptr_q + CW'(1);
  assign count_last = count_q - CW'(1);
  assign new_slot   = (count_q < hi_q) ? map_rd_q : count_q[PW-1:0];
  assign authed     = (auth_q != 3'd0);
  assign meth_mode  = (mode_q > MM_MAX_IN) ? MM_NOGRANT : mode_q[1:0];

  always_comb begin
    case (cmd_i.pos_sel)
      PA_NEXT:  pos_addr = ptr_nxt[PW-1:0];
      PA_COUNT: pos_addr = count_q[PW-1:0];
      PA_LAST:  pos_addr = count_last[PW-1:0];
      default:  pos_addr = ptr_q[PW-1:0];
    endcase
  end

  always_comb begin
    if (cmd_i.add_commit) begin
      pos_waddr = count_q[PW-1:0];
    end else if (cmd_i.right_commit) begin
      pos_waddr = idx_q;
    end else if (cmd_i.remove_commit) begin
      pos_waddr = count_last[PW-1:0];
    end else begin
      pos_waddr = ptr_q[PW-1:0];
    end
  end

  assign key_we  = cmd_i.add_commit | cmd_i.shift_write;
  assign acnt_we = key_we | (cmd_i.right_commit & (op_q == OP_ADD_ATTR));
  assign mcnt_we = key_we | (cmd_i.right_commit & (op_q == OP_ADD_METH));
  assign map_we  = key_we | cmd_i.remove_commit;
  assign attr_we = cmd_i.right_commit & (op_q == OP_ADD_ATTR);
  assign meth_we = cmd_i.right_commit & (op_q == OP_ADD_METH);

  assign key_wd  = cmd_i.shift_write ? key_rd_q : key_q;
  assign acnt_wd = cmd_i.add_commit ? '0 :
                   cmd_i.shift_write ? acnt_rd_q : ACW'(cnt_q + KW'(1));
  assign mcnt_wd = cmd_i.add_commit ? '0 :
                   cmd_i.shift_write ? mcnt_rd_q : MCW'(cnt_q + KW'(1));
  assign map_wd  = cmd_i.add_commit ? new_slot :
                   cmd_i.shift_write ? map_rd_q : slot_q;

  assign rk        = cmd_i.right_commit ? cnt_q : k_q;
  assign attr_addr = AAW'(AAW'(slot_q) * AAW'(ATTR_SLOTS) + AAW'(rk));
  assign meth_addr = MAW'(MAW'(slot_q) * MAW'(METHOD_SLOTS) + MAW'(rk));

  always_ff @(posedge clk_i) begin
    if (key_we)  key_mem[pos_waddr]  <= key_wd;
    if (acnt_we) acnt_mem[pos_waddr] <= acnt_wd;
    if (mcnt_we) mcnt_mem[pos_waddr] <= mcnt_wd;
    if (map_we)  map_mem[pos_waddr]  <= map_wd;
    key_rd_q  <= key_mem[pos_addr];
    acnt_rd_q <= acnt_mem[pos_addr];
    mcnt_rd_q <= mcnt_mem[pos_addr];
    map_rd_q  <= map_mem[pos_addr];
    rd_addr_q <= pos_addr;
  end

  always_ff @(posedge clk_i) begin
    if (attr_we) attr_mem[attr_addr] <= {id_q, mode_q};
    if (meth_we) meth_mem[meth_addr] <= {id_q, meth_mode};
    attr_rd_q <= attr_mem[attr_addr];
    meth_rd_q <= meth_mem[meth_addr];
  end

  // grant decision on the matched right
  always_comb begin
    grant = 1'b0;
    if (op_q == OP_INVOKE) begin
      case (meth_rd_q[1:0])
        MM_YES:  grant = 1'b1;
        MM_AUTH: grant = authed;
        default: grant = 1'b0;
      endcase
    end else if (op_q == OP_READ) begin
      case (attr_rd_q[2:0]) inside
        AM_R, AM_RW:           grant = 1'b1;
        AM_AUTH_R, AM_AUTH_RW: grant = authed;
        default:               grant = 1'b0;
      endcase
    end else begin
      case (attr_rd_q[2:0]) inside
        AM_W, AM_RW:           grant = 1'b1;
        AM_AUTH_W, AM_AUTH_RW: grant = authed;
        default:               grant = 1'b0;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= opcode_e'(opcode_i);
      key_q  <= {obj_class_i, obj_name_i};
      id_q   <= item_id_i;
      mode_q <= right_mode_i;
    end
    if (cmd_i.ptr_clr) begin
      ptr_q <= '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_q <= ptr_nxt;
    end
    if (cmd_i.k_clr) begin
      k_q <= '0;
    end else if (cmd_i.k_inc) begin
      k_q <= k_q + KW'(1);
    end
    if (cmd_i.capture) begin
      idx_q  <= rd_addr_q;
      slot_q <= map_rd_q;
      cnt_q  <= ((op_q == OP_ADD_METH) || (op_q == OP_INVOKE)) ?
                KW'(mcnt_rd_q) : KW'(acnt_rd_q);
    end else if (cmd_i.add_commit) begin
      idx_q <= count_q[PW-1:0];
    end
    if (cmd_i.res_set) begin
      case (cmd_i.res_kind)
        RK_OK_IDX: begin
          res_status_q <= ST_OK; res_allowed_q <= 1'b0; res_idx_q <= 6'(idx_q);
        end
        RK_NOROOM_ZERO: begin
          res_status_q <= ST_NOROOM; res_allowed_q <= 1'b0; res_idx_q <= '0;
        end
        RK_NOROOM_IDX: begin
          res_status_q <= ST_NOROOM; res_allowed_q <= 1'b0; res_idx_q <= 6'(idx_q);
        end
        RK_NOTFOUND: begin
          res_status_q <= ST_NOTFOUND; res_allowed_q <= 1'b0; res_idx_q <= '0;
        end
        RK_CHECK: begin
          res_status_q <= ST_OK; res_allowed_q <= grant; res_idx_q <= 6'(idx_q);
        end
        RK_CHECK_MISS: begin
          res_status_q <= ST_OK; res_allowed_q <= 1'b0; res_idx_q <= 6'(idx_q);
        end
        default: begin
          res_status_q <= ST_OK; res_allowed_q <= 1'b0; res_idx_q <= '0;
        end
      endcase
    end
    if (cmd_i.out_load) begin
      out_status_q  <= res_status_q;
      out_allowed_q <= res_allowed_q;
      out_idx_q     <= res_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      hi_q        <= '0;
      auth_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) auth_q <= cfg_wdata_i;
      if (cmd_i.clear_commit) begin
        count_q <= '0;
      end else if (cmd_i.add_commit) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.remove_commit) begin
        count_q <= count_last;
      end
      if (cmd_i.add_commit && (count_q == hi_q)) hi_q <= hi_q + CW'(1);
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.op         = op_q;
    stat_o.full       = (count_q >= CW'(MAX_ENTRIES));
    stat_o.empty      = (count_q == '0);
    stat_o.scan_end   = (ptr_q >= count_q);
    stat_o.key_hit    = (key_rd_q == key_q);
    stat_o.shift_end  = (ptr_nxt >= count_q);
    stat_o.right_end  = (k_q >= cnt_q);
    stat_o.right_hit  = (op_q == OP_INVOKE) ? (meth_rd_q[9:2] == id_q) :
                        (attr_rd_q[10:3] == id_q);
    stat_o.right_full = (op_q == OP_ADD_METH) ? (cnt_q >= KW'(METHOD_SLOTS)) :
                        (cnt_q >= KW'(ATTR_SLOTS));
    stat_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign allowed_o     = out_allowed_q;
  assign entry_index_o = out_idx_q;

  a_count_le_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hi_q) else $error("live count above slot high mark");
  a_hi_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_q <= CW'(MAX_ENTRIES)) else $error("slot high mark beyond table depth");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrote a word not yet taken");
  a_add_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_commit |-> (count_q < CW'(MAX_ENTRIES)))
    else $error("object added to a full table");

endmodule
